### rtl/core/table_sbox_xor_mix_block_cipher_core_assert.svh
// Assertion helpers shared by the cipher core RTL.
// Every check samples on the rising edge of clock and is off while reset is high.
`ifndef TABLE_SBOX_XOR_MIX_BLOCK_CIPHER_CORE_ASSERT_SVH
`define TABLE_SBOX_XOR_MIX_BLOCK_CIPHER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSXBC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSXBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/tsxbc_pkg.sv
package tsxbc_pkg;

   localparam int NUM_WORDS       = 12;
   localparam int WORD_W          = 16;
   localparam int TABLE_ENTRIES   = 65536;
   localparam int ADDR_W          = 16;
   localparam int NUM_TAPS        = 7;
   localparam int MAX_ROUNDS      = 32;
   localparam int RESET_ROUNDS    = 18;
   localparam int ROUND_W         = 6;
   localparam int GROUP_W         = 64;
   localparam int FUNC_W          = 2;
   localparam int SEL_W           = 4;
   localparam int TAP_W           = 4;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [NUM_WORDS-1:0] block_type;
   typedef logic [TAP_W-1:0] tap_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_FWD = 2'd0,
      FUNC_LOAD_INV = 2'd1,
      FUNC_ENCRYPT  = 2'd2,
      FUNC_DECRYPT  = 2'd3
   } func_type;

   // Each row lists the seven input words that are XORed into one output word.
   localparam tap_type MIX_TAPS [NUM_WORDS][NUM_TAPS] = '{
      '{4'd0, 4'd5, 4'd6, 4'd7, 4'd8,  4'd9,  4'd10},
      '{4'd1, 4'd4, 4'd5, 4'd6, 4'd9,  4'd10, 4'd11},
      '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6,  4'd8,  4'd10},
      '{4'd2, 4'd3, 4'd6, 4'd7, 4'd9,  4'd10, 4'd11},
      '{4'd1, 4'd2, 4'd4, 4'd6, 4'd7,  4'd8,  4'd9},
      '{4'd0, 4'd1, 4'd2, 4'd5, 4'd7,  4'd9,  4'd11},
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4,  4'd6,  4'd11},
      '{4'd0, 4'd3, 4'd4, 4'd5, 4'd7,  4'd10, 4'd11},
      '{4'd0, 4'd2, 4'd4, 4'd8, 4'd9,  4'd10, 4'd11},
      '{4'd0, 4'd1, 4'd3, 4'd4, 4'd5,  4'd8,  4'd9},
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd7,  4'd8,  4'd10},
      '{4'd1, 4'd3, 4'd5, 4'd6, 4'd7,  4'd8,  4'd11}
   };

   // Per-lane table control from the sequencer.
   typedef struct packed {
      logic wr_fwd;
      logic wr_inv;
      logic rd_en;
      logic rd_inv;
   } lane_ctrl_type;

endpackage

### rtl/core/tsxbc_chan_if.sv
interface tsxbc_req_if import tsxbc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [SEL_W-1:0]    box_select;
   logic [ADDR_W-1:0]   box_address;
   logic [WORD_W-1:0]   box_value;
   logic [GROUP_W-1:0]  in_words_0_3;
   logic [GROUP_W-1:0]  in_words_4_7;
   logic [GROUP_W-1:0]  in_words_8_11;

   modport source (
      output valid, func, box_select, box_address, box_value,
             in_words_0_3, in_words_4_7, in_words_8_11,
      input  ready
   );
   modport sink (
      input  valid, func, box_select, box_address, box_value,
             in_words_0_3, in_words_4_7, in_words_8_11,
      output ready
   );
endinterface

interface tsxbc_rsp_if import tsxbc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [GROUP_W-1:0]  out_words_0_3;
   logic [GROUP_W-1:0]  out_words_4_7;
   logic [GROUP_W-1:0]  out_words_8_11;

   modport source (
      output valid, out_words_0_3, out_words_4_7, out_words_8_11,
      input  ready
   );
   modport sink (
      input  valid, out_words_0_3, out_words_4_7, out_words_8_11,
      output ready
   );
endinterface

interface tsxbc_csr_if import tsxbc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ROUND_W-1:0]  round_count;

   modport source (output valid, round_count, input ready);
   modport sink (input valid, round_count, output ready);
endinterface

### rtl/core/table_sbox_xor_mix_block_cipher_core.sv
// Load words are taken one per cycle while the sequencer is idle and give no result.
// An encrypt or decrypt word with R rounds (R = round_count, capped at 32) runs one round
// per cycle, set by the table read loop, and its result is registered. The next word may
// enter once the sequencer is back in IDLE, later while the finished block waits for the
// output register. Reset (synchronous, active high) clears control, sets round_count to
// 18 and leaves the tables unwritten.
`include "table_sbox_xor_mix_block_cipher_core_assert.svh"

module table_sbox_xor_mix_block_cipher_core import tsxbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tsxbc_req_if.sink   req_bus,
   tsxbc_rsp_if.source rsp_bus,
   tsxbc_csr_if.sink   csr_bus
);

   // The sequencer waits for words in IDLE, issues the table reads of each round in ISSUE
   // and hands the block to the output register in FINISH.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [ROUND_W-1:0] round_count_ff, round_count_in;
   logic [ROUND_W-1:0] left_ff, left_in;
   logic               first_ff, first_in;
   logic               dec_ff, dec_in;
   block_type          words_ff, words_in;
   logic               rsp_valid_ff, rsp_valid_in;
   block_type          result_ff, result_in;

   logic               req_fire;
   func_type           req_func;
   block_type          in_block;
   logic [ROUND_W-1:0] rounds_sat;
   block_type          lane_dout;
   block_type          mix_in;
   block_type          mix_out;
   block_type          rd_block;
   block_type          final_block;
   logic               start_rounds;
   logic               last_round;
   logic               rsp_new;

   // Words are only taken while the sequencer is idle and reset is low; the output
   // register keeps the previous result separate, so a waiting result only blocks
   // acceptance while a finished block waits in FINISH for the register.
   assign req_bus.ready = !reset && (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_func      = func_type'(req_bus.func);
   assign in_block      = {req_bus.in_words_8_11, req_bus.in_words_4_7, req_bus.in_words_0_3};

   // The round count register is writable whenever reset is low.
   assign csr_bus.ready  = !reset;
   assign round_count_in = (csr_bus.valid && csr_bus.ready) ? csr_bus.round_count
                                                            : round_count_ff;
   assign rounds_sat     = (round_count_ff > ROUND_W'(MAX_ROUNDS)) ? ROUND_W'(MAX_ROUNDS)
                                                                   : round_count_ff;

   // Twelve lanes each hold the forward and inverse tables of one word position.
   // All lanes read in the same cycle, so a round costs one table access.
   for (genvar g = 0; g < NUM_WORDS; g++) begin : g_lane
      lane_ctrl_type ctrl;

      assign ctrl.wr_fwd = req_fire && (req_func == FUNC_LOAD_FWD)
                           && (req_bus.box_select == SEL_W'(g));
      assign ctrl.wr_inv = req_fire && (req_func == FUNC_LOAD_INV)
                           && (req_bus.box_select == SEL_W'(g));
      assign ctrl.rd_en  = (state_ff == ST_ISSUE);
      assign ctrl.rd_inv = dec_ff;

      tsxbc_lane u_lane (
         .clock   (clock),
         .ctrl    (ctrl),
         .wr_addr (req_bus.box_address),
         .wr_data (req_bus.box_value),
         .rd_addr (rd_block[g]),
         .rd_data (lane_dout[g])
      );
   end

   // Encryption substitutes then mixes, so the mix sits after the table read and
   // its output addresses the next round. Decryption mixes first, so the mix sits
   // in front of the read address and the table output is already the round result.
   // On the first round the block comes from the captured input instead of a lane.
   assign mix_in = (dec_ff && first_ff) ? words_ff : lane_dout;

   tsxbc_mix u_mix (
      .din  (mix_in),
      .dout (mix_out)
   );

   assign rd_block    = (!dec_ff && first_ff) ? words_ff : mix_out;
   assign final_block = first_ff ? words_ff : (dec_ff ? lane_dout : mix_out);

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      first_in     = first_ff;
      dec_in       = dec_ff;
      words_in     = words_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_func == FUNC_ENCRYPT || req_func == FUNC_DECRYPT)) begin
               words_in = in_block;
               dec_in   = (req_func == FUNC_DECRYPT);
               first_in = 1'b1;
               left_in  = rounds_sat;
               state_in = (rounds_sat == '0) ? ST_FINISH : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            first_in = 1'b0;
            left_in  = left_ff - ROUND_W'(1);
            if (left_ff == ROUND_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The lane outputs hold while no read is issued, so the result can
            // wait here until the output register is free.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               result_in    = final_block;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      words_ff  <= words_in;
      result_ff <= result_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         round_count_ff <= ROUND_W'(RESET_ROUNDS);
         left_ff        <= '0;
         first_ff       <= 1'b0;
         dec_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         round_count_ff <= round_count_in;
         left_ff        <= left_in;
         first_ff       <= first_in;
         dec_ff         <= dec_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.out_words_0_3  = result_ff[3:0];
   assign rsp_bus.out_words_4_7  = result_ff[7:4];
   assign rsp_bus.out_words_8_11 = result_ff[11:8];

   assign start_rounds = req_fire && (req_func == FUNC_ENCRYPT || req_func == FUNC_DECRYPT)
                         && (rounds_sat != '0);
   assign last_round   = (state_ff == ST_ISSUE) && (left_ff == ROUND_W'(1));
   assign rsp_new      = rsp_valid_in && !rsp_valid_ff;

   // The round counter never runs above the cap.
   `TSXBC_ASSERT_NOW(a_left_capped, 1'b1, left_ff <= ROUND_W'(MAX_ROUNDS), "round count over cap")
   // A cipher word with rounds to run starts issuing reads in the next cycle.
   `TSXBC_ASSERT_NEXT(a_start_issue, start_rounds, state_ff == ST_ISSUE, "rounds not started")
   // The last round read leads straight to the hand-off state.
   `TSXBC_ASSERT_NEXT(a_last_round, last_round, state_ff == ST_FINISH, "missed end of rounds")
   // A new result is only loaded from the hand-off state.
   `TSXBC_ASSERT_NOW(a_rsp_source, rsp_new, state_ff == ST_FINISH, "result without block")

endmodule

### rtl/core/tsxbc_ram.sv
module tsxbc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/tsxbc_lane.sv
// One word position: its forward and inverse tables. The read word holds
// while no read is issued.
module tsxbc_lane import tsxbc_pkg::*; (
   input  logic                clock,
   input  lane_ctrl_type       ctrl,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  word_type            wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output word_type            rd_data
);

   word_type fwd_data;
   word_type inv_data;

   tsxbc_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_ENTRIES)) u_fwd_ram (
      .clock   (clock),
      .wr_en   (ctrl.wr_fwd),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctrl.rd_en && !ctrl.rd_inv),
      .rd_addr (rd_addr),
      .rd_data (fwd_data)
   );

   tsxbc_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_ENTRIES)) u_inv_ram (
      .clock   (clock),
      .wr_en   (ctrl.wr_inv),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctrl.rd_en && ctrl.rd_inv),
      .rd_addr (rd_addr),
      .rd_data (inv_data)
   );

   assign rd_data = ctrl.rd_inv ? inv_data : fwd_data;

endmodule

### rtl/core/tsxbc_mix.sv
// Merging stage: each output word is the XOR of seven lane words.
module tsxbc_mix import tsxbc_pkg::*; (
   input  block_type din,
   output block_type dout
);

   always_comb begin
      word_type acc;
      acc = '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
         acc = '0;
         for (int k = 0; k < NUM_TAPS; k++) begin
            acc = acc ^ din[MIX_TAPS[i][k]];
         end
         dout[i] = acc;
      end
   end

endmodule

### verif/table_sbox_xor_mix_block_cipher_core_tb.sv
module table_sbox_xor_mix_block_cipher_core_tb import tsxbc_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   // Rough number of request words to send, and the cycle count after which the
   // run is declared hung. The slowest correct run (every word a 32 round block,
   // long sender gaps and receiver stalls) stays far below the limit.
   localparam int ITEM_TARGET = 1050;
   localparam int NUM_PHASES  = 8;
   localparam int CYCLE_LIMIT = 600000;

   // Idle profiles, applied to the phases in turn: none, sender only, receiver
   // only, and both sides at once.
   localparam int SEND_IDLE_PCT [4] = '{0, 56, 0, 13};
   localparam int RECV_STALL_PCT[4] = '{0, 0, 56, 13};

   // One request word as the sender puts it on the bus.
   typedef struct packed {
      func_type              func;
      logic [SEL_W-1:0]      sel;
      logic [ADDR_W-1:0]     addr;
      word_type              value;
      block_type             data;
   } cipher_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tsxbc_req_if req_bus();
   tsxbc_rsp_if rsp_bus();
   tsxbc_csr_if csr_bus();

   table_sbox_xor_mix_block_cipher_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Table contents live in one sparse store. The top key bit separates the
   // stimulus planner's copy (1) from the copy the result predictor keeps (0);
   // below it sit the inverse flag, the lane and the entry index.
   word_type box_mem [bit [21:0]];

   cipher_req_type       pending_q [$];
   logic [ROUND_W-1:0]   round_write_q [$];
   block_type            expected_blocks [$];

   // The round count the predictor believes is in force, and the one the
   // planner uses while it builds a phase.
   logic [ROUND_W-1:0]   round_setting = ROUND_W'(RESET_ROUNDS);
   logic [ROUND_W-1:0]   plan_rounds   = ROUND_W'(RESET_ROUNDS);

   word_type span_basis [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_made     = 0;
   int loads_seen     = 0;
   int encrypts_seen  = 0;
   int decrypts_seen  = 0;
   int blocks_checked = 0;
   int fail_count     = 0;
   int cycle_count    = 0;

   // Handshake flags captured at the rising edge and used by the drivers at the
   // following falling edge.
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Cipher arithmetic: the substitution layer and the seven-tap XOR mix.
   // ---------------------------------------------------------------------------

   function automatic word_type span_value();
      word_type v;
      v = '0;
      foreach (span_basis[k])
         if ($urandom_range(1)) v ^= span_basis[k];
      return v;
   endfunction

   function automatic block_type span_block();
      block_type b;
      for (int i = 0; i < NUM_WORDS; i++) b[i] = span_value();
      return b;
   endfunction

   function automatic block_type random_block();
      block_type b;
      for (int i = 0; i < NUM_WORDS; i++) b[i] = word_type'($urandom);
      return b;
   endfunction

   // Queue a table load. The planner's copy of the tables follows the queue
   // order, so later blocks in the queue are planned against it.
   function automatic void push_load(bit inv, logic [SEL_W-1:0] sel, word_type addr,
                                     word_type value);
      cipher_req_type r;
      r.func  = inv ? FUNC_LOAD_INV : FUNC_LOAD_FWD;
      r.sel   = sel;
      r.addr  = addr;
      r.value = value;
      r.data  = random_block();
      if (sel < NUM_WORDS) begin
         box_mem[{1'b1, inv, sel, addr}] = value;
         items_made++;
      end
      pending_q.push_back(r);
   endfunction

   // Substitute each lane through its own table. While planning, an entry that
   // has never been written is loaded first with a value from the current span,
   // so the core never reads an unwritten entry.
   function automatic block_type sbox_layer(block_type w, bit inv, bit plan);
      block_type s;
      bit [21:0] key;
      for (int i = 0; i < NUM_WORDS; i++) begin
         key = {plan, inv, 4'(i), w[i]};
         if (plan && !box_mem.exists(key)) push_load(inv, 4'(i), w[i], span_value());
         s[i] = box_mem.exists(key) ? box_mem[key] : '0;
      end
      return s;
   endfunction

   function automatic block_type xor_mix(block_type w);
      block_type t;
      for (int i = 0; i < NUM_WORDS; i++) begin
         t[i] = '0;
         for (int k = 0; k < NUM_TAPS; k++) t[i] ^= w[MIX_TAPS[i][k]];
      end
      return t;
   endfunction

   // Full cipher pass. Counts above the maximum saturate.
   function automatic block_type run_rounds(func_type f, block_type b,
                                            logic [ROUND_W-1:0] rounds, bit plan);
      block_type w;
      w = b;
      for (int r = 0; r < rounds && r < MAX_ROUNDS; r++) begin
         if (f == FUNC_ENCRYPT) begin
            w = xor_mix(sbox_layer(w, 1'b0, plan));
         end else begin
            w = sbox_layer(xor_mix(w), 1'b1, plan);
         end
      end
      return w;
   endfunction

   // Queue an encrypt or decrypt word. The table fields carry junk that the
   // core must ignore.
   function automatic void push_crypt(func_type f, block_type b);
      cipher_req_type r;
      void'(run_rounds(f, b, plan_rounds, 1'b1));
      r.func  = f;
      r.sel   = SEL_W'($urandom);
      r.addr  = ADDR_W'($urandom);
      r.value = WORD_W'($urandom);
      r.data  = b;
      items_made++;
      pending_q.push_back(r);
   endfunction

   // ---------------------------------------------------------------------------
   // Predictor and checker, both fed from the handshakes seen at rising edges.
   // ---------------------------------------------------------------------------

   function automatic void take_request(cipher_req_type r);
      if (r.func == FUNC_LOAD_FWD || r.func == FUNC_LOAD_INV) begin
         loads_seen++;
         if (r.sel < NUM_WORDS) box_mem[{1'b0, r.func == FUNC_LOAD_INV, r.sel, r.addr}] = r.value;
      end else begin
         if (r.func == FUNC_ENCRYPT) encrypts_seen++;
         else decrypts_seen++;
         expected_blocks.push_back(run_rounds(r.func, r.data, round_setting, 1'b0));
      end
   endfunction

   function automatic void check_block(block_type got);
      block_type want;
      if (expected_blocks.size() == 0) begin
         fail_count++;
         $display("%0t: result word with nothing outstanding, expected none actual %h",
                  $time, got);
         return;
      end
      want = expected_blocks.pop_front();
      blocks_checked++;
      for (int g = 0; g < 3; g++) begin
         if (want[g*4 +: 4] !== got[g*4 +: 4]) begin
            fail_count++;
            $display("%0t: out_words_%0d_%0d mismatch, expected %h actual %h", $time,
                     g * 4, g * 4 + 3, want[g*4 +: 4], got[g*4 +: 4]);
         end
      end
   endfunction

   always @(posedge clock) begin
      cipher_req_type seen;
      if (reset) begin
         req_taken <= 1'b0;
         csr_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         csr_taken <= csr_bus.valid && csr_bus.ready;
         // A new round count only applies to blocks accepted after it.
         if (csr_bus.valid && csr_bus.ready) round_setting = csr_bus.round_count;
         if (req_bus.valid && req_bus.ready) begin
            seen.func  = func_type'(req_bus.func);
            seen.sel   = req_bus.box_select;
            seen.addr  = req_bus.box_address;
            seen.value = req_bus.box_value;
            seen.data  = {req_bus.in_words_8_11, req_bus.in_words_4_7, req_bus.in_words_0_3};
            take_request(seen);
         end
         if (rsp_bus.valid && rsp_bus.ready)
            check_block({rsp_bus.out_words_8_11, rsp_bus.out_words_4_7, rsp_bus.out_words_0_3});
      end
   end

   // ---------------------------------------------------------------------------
   // Drivers. Everything changes at the falling edge; valid is assigned once
   // per edge so a word that follows straight on keeps it high.
   // ---------------------------------------------------------------------------

   always @(negedge clock) begin
      cipher_req_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = pending_q.pop_front();
            req_bus.valid         <= 1'b1;
            req_bus.func          <= item.func;
            req_bus.box_select    <= item.sel;
            req_bus.box_address   <= item.addr;
            req_bus.box_value     <= item.value;
            req_bus.in_words_0_3  <= item.data[3:0];
            req_bus.in_words_4_7  <= item.data[7:4];
            req_bus.in_words_8_11 <= item.data[11:8];
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= reset || ($urandom_range(99) >= recv_stall_pct);
   end

   always @(negedge clock) begin
      if (reset) begin
         csr_bus.valid <= 1'b0;
      end else if (!csr_bus.valid || csr_taken) begin
         if (round_write_q.size() != 0) begin
            csr_bus.valid       <= 1'b1;
            csr_bus.round_count <= round_write_q.pop_front();
         end else begin
            csr_bus.valid <= 1'b0;
         end
      end
   end

   // Hang guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: no progress after %0d cycles, %0d results still outstanding",
                  $time, cycle_count, expected_blocks.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencing.
   // ---------------------------------------------------------------------------

   // Wait until every queued word is in and every result is out, then give the
   // core time to finish a trailing load, which produces nothing to wait on.
   task automatic drain_and_settle();
      while (pending_q.size() != 0 || req_bus.valid || expected_blocks.size() != 0)
         @(posedge clock);
      repeat (MAX_ROUNDS + 4) @(posedge clock);
   endtask

   task automatic write_round_count(logic [ROUND_W-1:0] rounds);
      round_write_q.push_back(rounds);
      plan_rounds = rounds;
      while (round_write_q.size() != 0 || csr_bus.valid) @(posedge clock);
   endtask

   function automatic void new_span(int dim);
      span_basis.delete();
      repeat (dim) span_basis.push_back(word_type'($urandom));
   endfunction

   initial begin
      logic [ROUND_W-1:0] phase_setting [NUM_PHASES];
      int phase_end;
      int pick;

      req_bus.valid         = 1'b0;
      req_bus.func          = FUNC_LOAD_FWD;
      req_bus.box_select    = '0;
      req_bus.box_address   = '0;
      req_bus.box_value     = '0;
      req_bus.in_words_0_3  = '0;
      req_bus.in_words_4_7  = '0;
      req_bus.in_words_8_11 = '0;
      rsp_bus.ready         = 1'b1;
      csr_bus.valid         = 1'b0;
      csr_bus.round_count   = '0;

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed part, run at the reset round count. The span {0, FFFF} is closed
      // under the mix, so all-zero and all-ones blocks only touch two entries per
      // lane. Loads to lanes 12 and 15 must leave the tables alone.
      span_basis.delete();
      span_basis.push_back(16'hFFFF);
      push_load(1'b0, 4'd0, 16'hFFFF, 16'hFFFF);
      push_load(1'b1, 4'(NUM_WORDS - 1), 16'h0000, 16'h0000);
      push_load(1'b0, 4'(NUM_WORDS), 16'h0000, 16'h1234);
      push_load(1'b1, 4'd15, 16'hFFFF, 16'h0000);
      push_crypt(FUNC_ENCRYPT, '0);
      push_crypt(FUNC_ENCRYPT, '1);
      push_crypt(FUNC_DECRYPT, '0);
      push_crypt(FUNC_DECRYPT, '1);
      push_crypt(FUNC_ENCRYPT, span_block());
      push_crypt(FUNC_DECRYPT, span_block());
      drain_and_settle();

      // Round settings per phase: zero, one, the maximum, counts above the
      // maximum that must saturate (including the largest the field holds),
      // the reset value, five and one random count.
      phase_setting = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd18, 6'd33, 6'd5, 6'd0};
      phase_setting[NUM_PHASES - 1] = ROUND_W'($urandom_range(2, 31));

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_round_count(phase_setting[p]);
         send_idle_pct  = SEND_IDLE_PCT[p % 4];
         recv_stall_pct = RECV_STALL_PCT[p % 4];
         // A small XOR-closed span keeps most lookups on entries already loaded.
         new_span($urandom_range(1, 3));
         phase_end = items_made + (ITEM_TARGET - items_made) / (NUM_PHASES - p);
         while (items_made < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
               push_crypt($urandom_range(1) ? FUNC_ENCRYPT : FUNC_DECRYPT, span_block());
            end else if (pick < 72) begin
               // Arbitrary blocks: the first lookups fall anywhere in the tables.
               push_crypt($urandom_range(1) ? FUNC_ENCRYPT : FUNC_DECRYPT, random_block());
            end else if (pick < 80) begin
               // Overwrite a live entry inside the span.
               push_load($urandom_range(1), 4'($urandom_range(NUM_WORDS - 1)),
                         span_value(), span_value());
            end else if (pick < 92) begin
               push_load($urandom_range(1), 4'($urandom_range(15)),
                         word_type'($urandom), word_type'($urandom));
            end else begin
               push_load($urandom_range(1), 4'($urandom_range(15, NUM_WORDS)),
                         word_type'($urandom), word_type'($urandom));
            end
         end
         drain_and_settle();
      end

      $display("Sent %0d loads, %0d encrypts and %0d decrypts over %0d round settings,",
               loads_seen, encrypts_seen, decrypts_seen, NUM_PHASES + 1);
      $display("checked %0d result blocks under four idle profiles, %0d failures.",
               blocks_checked, fail_count);
      if (fail_count == 0 && expected_blocks.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### table_sbox_xor_mix_block_cipher_core.f
+incdir+rtl/core
rtl/core/tsxbc_pkg.sv
rtl/core/tsxbc_chan_if.sv
rtl/core/tsxbc_ram.sv
rtl/core/tsxbc_lane.sv
rtl/core/tsxbc_mix.sv
rtl/core/table_sbox_xor_mix_block_cipher_core.sv
verif/table_sbox_xor_mix_block_cipher_core_tb.sv
